// ===== sv/thread_id_allocator_map_unit_macros.svh =====
// ----------------------------------------------------------------------------
// thread id allocator assertion macros
// shorthand for the concurrent checks used at the top level
// ----------------------------------------------------------------------------
`ifndef THREAD_ID_ALLOCATOR_MAP_UNIT_MACROS_SVH
`define THREAD_ID_ALLOCATOR_MAP_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define TIDAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define TIDAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tidam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tidam_pkg
// shared types, codes and defaults of the thread id allocator
// ----------------------------------------------------------------------------
package tidam_pkg;

  // default sizes
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int FREE_DEPTH_DEF  = 64;
  localparam int ID_BITS_DEF     = 16;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int GID_W    = 16;
  localparam int HANDLE_W = 32;
  localparam int STAT_W   = 3;

  // reset value of the first recyclable id
  localparam logic [GID_W-1:0] FDI_RESET = 16'd64;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_ID = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd2;
  localparam logic [OP_W-1:0] OP_FREE     = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_CTR = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STS_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STS_NOT_FOUND  = 3'd1;
  localparam logic [STAT_W-1:0] STS_DUPLICATE  = 3'd2;
  localparam logic [STAT_W-1:0] STS_TABLE_FULL = 3'd3;
  localparam logic [STAT_W-1:0] STS_EXHAUSTED  = 3'd4;
  localparam logic [STAT_W-1:0] STS_STACK_FULL = 3'd5;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_SCAN,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic pop_rd;
    logic scan_step;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_pop;
    logic in_scan;
    logic clear_last;
    logic scan_last;
  } dp_sts_t;

endpackage

// ===== sv/thread_id_allocator_map_unit.sv =====
`timescale 1ns / 1ps
// sequence: accept, a pop of the free stack when allocate recycles an id, a walk over every
// table entry for allocate, lookup and free, then completion and the registered result
// throughput: a new transaction is taken only once the last one is done; the walk over the
// entry ram's single read port sets the pace. busy is low again in the cycle that out_valid is shown
// reset: synchronous on rst_n low, then a clearing pass over every entry of the
// entry ram with busy high; configuration writes are taken during it
// ----------------------------------------------------------------------------
// thread_id_allocator_map_unit
// thread id allocator with lifo free list and id to task handle map
// ----------------------------------------------------------------------------
`include "thread_id_allocator_map_unit_macros.svh"

module thread_id_allocator_map_unit #(
  parameter int TABLE_DEPTH = tidam_pkg::TABLE_DEPTH_DEF,
  parameter int FREE_DEPTH  = tidam_pkg::FREE_DEPTH_DEF,
  parameter int ID_BITS     = tidam_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [tidam_pkg::OP_W-1:0]      in_operation,
  input  logic [tidam_pkg::GID_W-1:0]     in_given_id,
  input  logic [tidam_pkg::HANDLE_W-1:0]  in_task_handle,
  input  logic                            cfg_wr_en,
  input  logic [tidam_pkg::GID_W-1:0]     cfg_wr_data,
  output logic                            out_valid,
  output logic [tidam_pkg::GID_W-1:0]     out_result_id,
  output logic [tidam_pkg::HANDLE_W-1:0]  out_found_handle,
  output logic [tidam_pkg::STAT_W-1:0]    out_status
);

  tidam_pkg::ctrl_cmd_t cmd;
  tidam_pkg::dp_sts_t   sts;

  // sequencer
  tidam_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // storage and search datapath
  tidam_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FREE_DEPTH  (FREE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_given_id      (in_given_id),
    .in_task_handle   (in_task_handle),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_result_id    (out_result_id),
    .out_found_handle (out_found_handle),
    .out_status       (out_status)
  );

  // checks
  `TIDAM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `TIDAM_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `TIDAM_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while the block is busy")
  `TIDAM_ASSERT_NOW(a_status_range, out_valid, out_status <= tidam_pkg::STS_STACK_FULL, "status code out of range")

endmodule

// ===== sv/tidam_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tidam_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tidam_ram #(
  parameter int WIDTH = tidam_pkg::ID_BITS_DEF,
  parameter int DEPTH = tidam_pkg::TABLE_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tidam_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tidam_ctrl
// sequencer: clearing pass, free stack pop, table walk and completion
// ----------------------------------------------------------------------------
module tidam_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  tidam_pkg::dp_sts_t    sts,
  output tidam_pkg::ctrl_cmd_t  cmd,
  output logic                  busy
);

  tidam_pkg::state_t state_r, state_nxt;

  // state register, clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tidam_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      tidam_pkg::S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = tidam_pkg::S_IDLE;
        end
      end
      tidam_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          if (sts.in_pop) begin
            state_nxt = tidam_pkg::S_POP;
          end else if (sts.in_scan) begin
            state_nxt = tidam_pkg::S_SCAN;
          end else begin
            state_nxt = tidam_pkg::S_DONE;
          end
        end
      end
      tidam_pkg::S_POP: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = tidam_pkg::S_SCAN;
      end
      tidam_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = tidam_pkg::S_DONE;
        end
      end
      tidam_pkg::S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = tidam_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tidam_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/tidam_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tidam_dp
// datapath: entry table and free stack rams, id counter, search and update
// ----------------------------------------------------------------------------
module tidam_dp #(
  parameter int TABLE_DEPTH = tidam_pkg::TABLE_DEPTH_DEF,
  parameter int FREE_DEPTH  = tidam_pkg::FREE_DEPTH_DEF,
  parameter int ID_BITS     = tidam_pkg::ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tidam_pkg::ctrl_cmd_t             cmd,
  output tidam_pkg::dp_sts_t               sts,
  input  logic [tidam_pkg::OP_W-1:0]       in_operation,
  input  logic [tidam_pkg::GID_W-1:0]      in_given_id,
  input  logic [tidam_pkg::HANDLE_W-1:0]   in_task_handle,
  input  logic                             cfg_wr_en,
  input  logic [tidam_pkg::GID_W-1:0]      cfg_wr_data,
  output logic                             out_valid,
  output logic [tidam_pkg::GID_W-1:0]      out_result_id,
  output logic [tidam_pkg::HANDLE_W-1:0]   out_found_handle,
  output logic [tidam_pkg::STAT_W-1:0]     out_status
);

  localparam int HW    = tidam_pkg::HANDLE_W;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SA_W  = $clog2(FREE_DEPTH);
  localparam int SC_W  = $clog2(FREE_DEPTH + 1);
  localparam int EW    = 1 + ID_BITS + HW;
  localparam logic [31:0] FDI_RST32 = 32'(tidam_pkg::FDI_RESET);

  // latched transaction and search state
  logic [tidam_pkg::OP_W-1:0] op_r;
  logic [ID_BITS-1:0]         gid_r;
  logic [HW-1:0]              handle_r;
  logic [CNT_W-1:0]           scan_cnt_r;
  logic                       hit_r;
  logic [IDX_W-1:0]           hit_idx_r;
  logic [HW-1:0]              hit_handle_r;
  logic                       free_r;
  logic [IDX_W-1:0]           free_idx_r;

  // architectural state
  logic [ID_BITS-1:0]         fdi_r;
  logic [ID_BITS-1:0]         ctr_r, ctr_nxt;
  logic [SC_W-1:0]            stk_cnt_r, stk_cnt_nxt;

  // result registers
  logic                       out_valid_r;
  logic [tidam_pkg::GID_W-1:0]   rid_out_r;
  logic [HW-1:0]              fh_out_r;
  logic [tidam_pkg::STAT_W-1:0]  st_out_r;

  // ram ports
  logic             ent_we, ent_re;
  logic [IDX_W-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0]    ent_wdata, ent_rdata;
  logic             stk_we;
  logic [SA_W-1:0]  stk_waddr, stk_raddr;
  logic [ID_BITS-1:0] stk_wdata, stk_rdata;

  // combinational helpers
  logic [31:0]        gid_ext, cfg_ext, rid_ext;
  logic [ID_BITS-1:0] gid_in, cfg_id, key;
  logic [SC_W-1:0]    stk_top;
  logic [CNT_W-1:0]   eval_cnt;
  logic [IDX_W-1:0]   eval_idx;
  logic               e_valid;
  logic [ID_BITS-1:0] e_id;
  logic [HW-1:0]      e_handle;
  logic               eval_en;
  logic               stk_empty;
  logic [ID_BITS-1:0] rid_c;
  logic [HW-1:0]      fh_c;
  logic [tidam_pkg::STAT_W-1:0] st_c;
  logic               done_we;
  logic [IDX_W-1:0]   done_waddr;
  logic [EW-1:0]      done_wdata;

  // ids are taken modulo 2^ID_BITS
  assign gid_ext = {16'd0, in_given_id};
  assign cfg_ext = {16'd0, cfg_wr_data};
  assign gid_in  = gid_ext[ID_BITS-1:0];
  assign cfg_id  = cfg_ext[ID_BITS-1:0];

  // status towards the controller
  always_comb begin
    sts.in_pop     = (in_operation == tidam_pkg::OP_ALLOC) && (stk_cnt_r != '0);
    sts.in_scan    = 1'b0;
    unique case (in_operation) inside
      tidam_pkg::OP_ALLOC, tidam_pkg::OP_ALLOC_ID,
      tidam_pkg::OP_LOOKUP, tidam_pkg::OP_FREE: sts.in_scan = 1'b1;
      default: sts.in_scan = 1'b0;
    endcase
    sts.clear_last = (scan_cnt_r == CNT_W'(TABLE_DEPTH - 1));
    sts.scan_last  = (scan_cnt_r == CNT_W'(TABLE_DEPTH));
  end

  assign stk_empty = (stk_cnt_r == '0);
  assign stk_top   = stk_cnt_r - SC_W'(1);
  assign stk_raddr = stk_top[SA_W-1:0];

  // search key: recycled id, counter, or the given id
  assign key = (op_r == tidam_pkg::OP_ALLOC) ? (stk_empty ? ctr_r : stk_rdata) : gid_r;

  // table walk: read issued at scan_cnt, data checked in the following cycle
  assign ent_re    = cmd.scan_step && (scan_cnt_r < CNT_W'(TABLE_DEPTH));
  assign ent_raddr = scan_cnt_r[IDX_W-1:0];
  assign eval_en   = cmd.scan_step && (scan_cnt_r != '0);
  assign eval_cnt  = scan_cnt_r - CNT_W'(1);
  assign eval_idx  = eval_cnt[IDX_W-1:0];
  assign e_valid   = ent_rdata[EW-1];
  assign e_id      = ent_rdata[HW +: ID_BITS];
  assign e_handle  = ent_rdata[HW-1:0];

  // transaction latch, walk counter and search results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else if (cmd.accept) begin
      scan_cnt_r <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else if (cmd.clear_wr) begin
      scan_cnt_r <= scan_cnt_r + CNT_W'(1);
    end else if (cmd.scan_step) begin
      scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      if (eval_en && e_valid && (e_id == key) && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (eval_en && !e_valid && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_operation;
      gid_r    <= gid_in;
      handle_r <= in_task_handle;
    end
    if (eval_en && e_valid && (e_id == key) && !hit_r) begin
      hit_idx_r    <= eval_idx;
      hit_handle_r <= e_handle;
    end
    if (eval_en && !e_valid && !free_r) begin
      free_idx_r <= eval_idx;
    end
  end

  // completion: result and state updates
  always_comb begin
    rid_c       = '0;
    fh_c        = '0;
    st_c        = tidam_pkg::STS_OK;
    done_we     = 1'b0;
    done_waddr  = free_idx_r;
    done_wdata  = {1'b1, key, handle_r};
    stk_we      = 1'b0;
    stk_waddr   = stk_cnt_r[SA_W-1:0];
    stk_wdata   = gid_r;
    ctr_nxt     = ctr_r;
    stk_cnt_nxt = stk_cnt_r;
    unique case (op_r)
      tidam_pkg::OP_ALLOC: begin
        if (!free_r) begin
          st_c = tidam_pkg::STS_TABLE_FULL;
        end else if (stk_empty && (ctr_r == '1)) begin
          st_c = tidam_pkg::STS_EXHAUSTED;
        end else begin
          rid_c = key;
          if (stk_empty) begin
            ctr_nxt = ctr_r + ID_BITS'(1);
          end else begin
            stk_cnt_nxt = stk_top;
          end
          if (hit_r) begin
            st_c = tidam_pkg::STS_DUPLICATE;
          end else begin
            done_we = 1'b1;
          end
        end
      end
      tidam_pkg::OP_ALLOC_ID: begin
        rid_c = gid_r;
        if (hit_r) begin
          st_c = tidam_pkg::STS_DUPLICATE;
        end else if (!free_r) begin
          st_c = tidam_pkg::STS_TABLE_FULL;
        end else begin
          done_we = 1'b1;
        end
      end
      tidam_pkg::OP_LOOKUP: begin
        rid_c = gid_r;
        if (hit_r) begin
          fh_c = hit_handle_r;
        end else begin
          st_c = tidam_pkg::STS_NOT_FOUND;
        end
      end
      tidam_pkg::OP_FREE: begin
        rid_c = gid_r;
        if (!hit_r) begin
          st_c = tidam_pkg::STS_NOT_FOUND;
        end else begin
          fh_c       = hit_handle_r;
          done_we    = 1'b1;
          done_waddr = hit_idx_r;
          done_wdata = {1'b0, gid_r, handle_r};
          if (gid_r >= fdi_r) begin
            if (stk_cnt_r < SC_W'(FREE_DEPTH)) begin
              stk_we      = 1'b1;
              stk_cnt_nxt = stk_cnt_r + SC_W'(1);
            end else begin
              st_c = tidam_pkg::STS_STACK_FULL;
            end
          end
        end
      end
      tidam_pkg::OP_READ_CTR: begin
        rid_c = ctr_r;
      end
      default: begin
        rid_c = '0;
      end
    endcase
  end

  // entry write port: clearing pass or completion
  always_comb begin
    if (cmd.clear_wr) begin
      ent_we    = 1'b1;
      ent_waddr = scan_cnt_r[IDX_W-1:0];
      ent_wdata = '0;
    end else begin
      ent_we    = cmd.finish && done_we;
      ent_waddr = done_waddr;
      ent_wdata = done_wdata;
    end
  end

  // register, counter and stack depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fdi_r     <= FDI_RST32[ID_BITS-1:0];
      ctr_r     <= FDI_RST32[ID_BITS-1:0];
      stk_cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        fdi_r <= cfg_id;
        ctr_r <= cfg_id;
      end else if (cmd.finish) begin
        ctr_r <= ctr_nxt;
      end
      if (cmd.finish) begin
        stk_cnt_r <= stk_cnt_nxt;
      end
    end
  end

  // result strobe and payload
  assign rid_ext = 32'(rid_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rid_out_r <= rid_ext[tidam_pkg::GID_W-1:0];
      fh_out_r  <= fh_c;
      st_out_r  <= st_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_id    = rid_out_r;
  assign out_found_handle = fh_out_r;
  assign out_status       = st_out_r;

  // entry table: valid, id and handle per slot
  tidam_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // lifo of recycled ids
  tidam_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (FREE_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (cmd.finish && stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (cmd.pop_rd),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

// ===== tb/thread_id_allocator_map_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_id_allocator_map_unit_tb
// self-checking bench for the thread id allocator: a directed script with
// partly hand-read replies, then randomised phases over several first-id settings
// that fill and empty the map and the free stack, checked against a
// cycle-free model of the id map kept inside the bench
// ----------------------------------------------------------------------------
module thread_id_allocator_map_unit_tb;
  import tidam_pkg::*;

  localparam int TD = TABLE_DEPTH_DEF;
  localparam int FD = FREE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DIR_ROWS = 25;
  localparam int PHASES = 10;
  localparam logic [GID_W-1:0] ID_ALL_ONES = '1;

  // operation codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_MID   = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic [GID_W-1:0]    result_id;
    logic [HANDLE_W-1:0] found_handle;
    logic [STAT_W-1:0]   status;
  } reply_t;

  localparam reply_t NO_REPLY = '0;

  typedef struct packed {
    bit                  is_cfg;
    logic [OP_W-1:0]     op;
    logic [GID_W-1:0]    gid;
    logic [HANDLE_W-1:0] handle;
    bit                  typed;
    reply_t              want;
  } script_row_t;

  typedef enum logic [1:0] {MIX_GENERAL, MIX_BIND, MIX_RELEASE, MIX_CHURN} mix_t;

  typedef struct packed {
    bit               write_cfg;
    bit               rand_cfg;
    logic [GID_W-1:0] cfg_val;
    mix_t             mix;
    int               items;
    bit               quiet;
  } phase_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] in_operation = '0;
  logic [GID_W-1:0] in_given_id = '0;
  logic [HANDLE_W-1:0] in_task_handle = '0;
  logic cfg_wr_en = 1'b0;
  logic [GID_W-1:0] cfg_wr_data = '0;
  logic out_valid;
  logic [GID_W-1:0] out_result_id;
  logic [HANDLE_W-1:0] out_found_handle;
  logic [STAT_W-1:0] out_status;

  // model of the id map
  logic [GID_W-1:0] map_fdi = FDI_RESET;
  logic [GID_W-1:0] map_counter = FDI_RESET;
  logic [GID_W-1:0] recycle_stack [FD];
  int recycle_depth = 0;
  bit bind_valid [TD];
  logic [GID_W-1:0] bind_id [TD];
  logic [HANDLE_W-1:0] bind_handle [TD];

  reply_t awaited_replies [$];
  bit quiet = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int replies_seen = 0;
  int settings_used = 0;
  int status_hits [8];
  int cycle_count = 0;

  // op weights per mix: alloc, alloc with id, lookup, free, read counter, reserved
  int mix_weight [4][6] = '{
    '{25, 15, 20, 25, 10, 5},
    '{ 8, 70, 10,  5,  4, 3},
    '{ 3,  5, 10, 75,  4, 3},
    '{45,  4,  8, 35,  5, 3}
  };
  logic [OP_W-1:0] op_order [6] = '{OP_ALLOC, OP_ALLOC_ID, OP_LOOKUP, OP_FREE, OP_READ_CTR,
                                    OP_RSVD_FIRST};

  // directed script, first-id starts at its reset value
  script_row_t directed_script [DIR_ROWS] = '{
    '{1'b0, OP_READ_CTR, 16'd0, 32'd0, 1'b1, '{16'd64, 32'd0, STS_OK}},
    '{1'b0, OP_LOOKUP, 16'd0, 32'd0, 1'b1, '{16'd0, 32'd0, STS_NOT_FOUND}},
    '{1'b0, OP_FREE, 16'hFFFF, 32'd0, 1'b1, '{16'hFFFF, 32'd0, STS_NOT_FOUND}},
    '{1'b0, OP_ALLOC, 16'd0, 32'hFFFF_FFFF, 1'b1, '{16'd64, 32'd0, STS_OK}},
    '{1'b0, OP_ALLOC, 16'd0, 32'd0, 1'b1, '{16'd65, 32'd0, STS_OK}},
    '{1'b0, OP_LOOKUP, 16'd64, 32'd0, 1'b1, '{16'd64, 32'hFFFF_FFFF, STS_OK}},
    '{1'b0, OP_ALLOC_ID, 16'd66, 32'hA5A5_5A5A, 1'b0, NO_REPLY},
    '{1'b0, OP_ALLOC, 16'd0, 32'd1, 1'b1, '{16'd66, 32'd0, STS_DUPLICATE}},
    '{1'b0, OP_ALLOC_ID, 16'd64, 32'd2, 1'b1, '{16'd64, 32'd0, STS_DUPLICATE}},
    '{1'b0, OP_ALLOC_ID, 16'd0, 32'h1234_5678, 1'b0, NO_REPLY},
    '{1'b0, OP_FREE, 16'd0, 32'd0, 1'b1, '{16'd0, 32'h1234_5678, STS_OK}},
    '{1'b0, OP_FREE, 16'd64, 32'd0, 1'b1, '{16'd64, 32'hFFFF_FFFF, STS_OK}},
    '{1'b0, OP_FREE, 16'd65, 32'd0, 1'b0, NO_REPLY},
    '{1'b0, OP_ALLOC, 16'd0, 32'd3, 1'b0, NO_REPLY},
    '{1'b0, OP_ALLOC, 16'd0, 32'd4, 1'b0, NO_REPLY},
    '{1'b0, OP_ALLOC, 16'd0, 32'd5, 1'b0, NO_REPLY},
    '{1'b0, OP_RSVD_FIRST, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, NO_REPLY},
    '{1'b0, OP_RSVD_MID, 16'h5555, 32'h5555_5555, 1'b1, NO_REPLY},
    '{1'b0, OP_RSVD_LAST, 16'hAAAA, 32'hAAAA_AAAA, 1'b1, NO_REPLY},
    '{1'b0, OP_ALLOC_ID, 16'hFFFF, 32'hC3C3_C3C3, 1'b0, NO_REPLY},
    '{1'b0, OP_FREE, 16'hFFFF, 32'd0, 1'b0, NO_REPLY},
    '{1'b1, OP_ALLOC, 16'hFFFF, 32'd0, 1'b0, NO_REPLY},
    '{1'b0, OP_READ_CTR, 16'd0, 32'd0, 1'b1, '{16'hFFFF, 32'd0, STS_OK}},
    '{1'b0, OP_ALLOC, 16'd0, 32'd6, 1'b0, NO_REPLY},
    '{1'b0, OP_ALLOC, 16'd0, 32'd7, 1'b1, '{16'd0, 32'd0, STS_EXHAUSTED}}
  };

  // random phases: fill, empty and churn the map under several first-id values
  phase_t campaign [PHASES] = '{
    '{1'b1, 1'b0, 16'd1,     MIX_GENERAL, 120, 1'b0},
    '{1'b1, 1'b1, 16'd0,     MIX_BIND,    110, 1'b0},
    '{1'b0, 1'b0, 16'd0,     MIX_RELEASE, 110, 1'b0},
    '{1'b0, 1'b0, 16'd0,     MIX_BIND,    100, 1'b0},
    '{1'b0, 1'b0, 16'd0,     MIX_RELEASE, 100, 1'b0},
    '{1'b1, 1'b0, 16'hFFFE,  MIX_CHURN,   140, 1'b0},
    '{1'b1, 1'b1, 16'd0,     MIX_GENERAL, 150, 1'b1},
    '{1'b1, 1'b0, 16'hFFFF,  MIX_CHURN,    90, 1'b0},
    '{1'b1, 1'b1, 16'd0,     MIX_BIND,     70, 1'b0},
    '{1'b0, 1'b0, 16'd0,     MIX_RELEASE,  70, 1'b0}
  };

  thread_id_allocator_map_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_given_id      (in_given_id),
    .in_task_handle   (in_task_handle),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_result_id    (out_result_id),
    .out_found_handle (out_found_handle),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // slot holding a bound id, or -1
  function automatic int slot_of(input logic [GID_W-1:0] id);
    for (int k = 0; k < TD; k++)
      if (bind_valid[k] && bind_id[k] == id) return k;
    return -1;
  endfunction

  // lowest unused slot, or -1 when the map is full
  function automatic int empty_slot();
    for (int k = 0; k < TD; k++)
      if (!bind_valid[k]) return k;
    return -1;
  endfunction

  // applies one transaction to the id map and returns the reply it gives
  function automatic reply_t apply_thread_op(input logic [OP_W-1:0] op,
                                             input logic [GID_W-1:0] gid,
                                             input logic [HANDLE_W-1:0] handle);
    reply_t r;
    int slot;
    int hit;
    logic [GID_W-1:0] id;
    r = '0;
    case (op)
      OP_ALLOC: begin
        slot = empty_slot();
        if (slot < 0) begin
          r.status = STS_TABLE_FULL;
        end else if (recycle_depth == 0 && map_counter == ID_ALL_ONES) begin
          r.status = STS_EXHAUSTED;
        end else begin
          // recycled ids win over the counter
          if (recycle_depth > 0) begin
            recycle_depth--;
            id = recycle_stack[recycle_depth];
          end else begin
            id = map_counter;
            map_counter = map_counter + 1'b1;
          end
          r.result_id = id;
          if (slot_of(id) >= 0) begin
            r.status = STS_DUPLICATE;
          end else begin
            bind_valid[slot] = 1'b1;
            bind_id[slot] = id;
            bind_handle[slot] = handle;
          end
        end
      end
      OP_ALLOC_ID: begin
        r.result_id = gid;
        slot = empty_slot();
        if (slot_of(gid) >= 0) begin
          r.status = STS_DUPLICATE;
        end else if (slot < 0) begin
          r.status = STS_TABLE_FULL;
        end else begin
          bind_valid[slot] = 1'b1;
          bind_id[slot] = gid;
          bind_handle[slot] = handle;
        end
      end
      OP_LOOKUP: begin
        r.result_id = gid;
        hit = slot_of(gid);
        if (hit < 0) r.status = STS_NOT_FOUND;
        else r.found_handle = bind_handle[hit];
      end
      OP_FREE: begin
        r.result_id = gid;
        hit = slot_of(gid);
        if (hit < 0) begin
          r.status = STS_NOT_FOUND;
        end else begin
          r.found_handle = bind_handle[hit];
          bind_valid[hit] = 1'b0;
          // only dynamic ids go back on the stack, dropped when it is full
          if (gid >= map_fdi) begin
            if (recycle_depth < FD) begin
              recycle_stack[recycle_depth] = gid;
              recycle_depth++;
            end else begin
              r.status = STS_STACK_FULL;
            end
          end
        end
      end
      OP_READ_CTR: r.result_id = map_counter;
      default: ;
    endcase
    return r;
  endfunction

  // random bound id, falls back to a random value on an empty map
  function automatic logic [GID_W-1:0] pick_bound_id();
    int base;
    base = $urandom_range(0, TD - 1);
    for (int k = 0; k < TD; k++)
      if (bind_valid[(base + k) % TD]) return bind_id[(base + k) % TD];
    return GID_W'($urandom());
  endfunction

  // present one transaction, wait for acceptance and log its reply
  task automatic issue(input logic [OP_W-1:0] op, input logic [GID_W-1:0] gid,
                       input logic [HANDLE_W-1:0] handle, input bit typed,
                       input reply_t want);
    int gap;
    reply_t predicted;
    gap = 0;
    if (!quiet)
      while ($urandom_range(0, 99) < 19) gap += $urandom_range(1, 90);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_given_id <= gid;
    in_task_handle <= handle;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_thread_op(op, gid, handle);
    awaited_replies.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // drop start and hold off until every reply is back
  task automatic drain_replies();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  // first-id write, only with the block idle
  task automatic program_first_id(input logic [GID_W-1:0] value);
    drain_replies();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    map_fdi = value;
    map_counter = value;
    settings_used++;
  endtask

  // one random transaction shaped by the phase mix
  task automatic random_item(input mix_t mix);
    logic [OP_W-1:0] op;
    logic [GID_W-1:0] gid;
    logic [HANDLE_W-1:0] handle;
    int r;
    int acc;
    int pick;
    int sel;
    r = $urandom_range(0, 99);
    acc = 0;
    sel = 5;
    for (int k = 0; k < 6; k++) begin
      acc += mix_weight[int'(mix)][k];
      if (r < acc && sel == 5 && acc - mix_weight[int'(mix)][k] <= r) sel = k;
    end
    op = op_order[sel];
    if (op == OP_RSVD_FIRST) op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    gid = GID_W'($urandom());
    pick = $urandom_range(0, 99);
    case (op)
      OP_ALLOC_ID: begin
        if (pick < 60) begin
          gid = map_fdi + GID_W'($urandom_range(0, 1500));
        end else if (pick < 75) begin
          gid = pick_bound_id();
        end else if (pick >= 90) begin
          case ($urandom_range(0, 3))
            0: gid = '0;
            1: gid = '1;
            2: gid = map_fdi - 1'b1;
            default: gid = map_fdi;
          endcase
        end
      end
      OP_LOOKUP, OP_FREE: begin
        if (pick < 80) gid = pick_bound_id();
        else if (pick < 88 && recycle_depth > 0) gid = recycle_stack[recycle_depth - 1];
      end
      default: ;
    endcase
    case ($urandom_range(0, 19))
      0: handle = '0;
      1: handle = '1;
      default: handle = $urandom();
    endcase
    issue(op, gid, handle, 1'b0, NO_REPLY);
  endtask

  // reply checker
  always @(posedge clk) begin : reply_check
    reply_t want;
    reply_t got;
    if (rst_n && out_valid === 1'b1) begin
      got = '{out_result_id, out_found_handle, out_status};
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: reply with none outstanding: id %h handle %h status %0d",
                 $time, got.result_id, got.found_handle, got.status);
      end else begin
        want = awaited_replies.pop_front();
        replies_seen++;
        status_hits[got.status]++;
        if (got.result_id !== want.result_id || got.found_handle !== want.found_handle ||
            got.status !== want.status) begin
          errors++;
          $display("%0t: mismatch id exp %h got %h, handle exp %h got %h, status exp %0d got %0d",
                   $time, want.result_id, got.result_id, want.found_handle,
                   got.found_handle, want.status, got.status);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("thread_id_allocator_map_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed script
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed_script[i].is_cfg)
        program_first_id(directed_script[i].gid);
      else
        issue(directed_script[i].op, directed_script[i].gid, directed_script[i].handle,
              directed_script[i].typed, directed_script[i].want);
    end

    // random phases, each begins with the block drained
    for (int p = 0; p < PHASES; p++) begin
      if (campaign[p].write_cfg)
        program_first_id(campaign[p].rand_cfg ? GID_W'($urandom_range(2, 65533))
                                              : campaign[p].cfg_val);
      else
        drain_replies();
      quiet = campaign[p].quiet;
      for (int n = 0; n < campaign[p].items; n++) random_item(campaign[p].mix);
    end

    drain_replies();
    repeat (TD + 8) @(posedge clk);
    $display("covered %0d transactions, %0d replies checked, %0d first-id settings",
             items_sent, replies_seen, settings_used);
    $display("statuses: ok %0d, not found %0d, duplicate %0d, map full %0d, exhausted %0d, stack full %0d",
             status_hits[STS_OK], status_hits[STS_NOT_FOUND], status_hits[STS_DUPLICATE],
             status_hits[STS_TABLE_FULL], status_hits[STS_EXHAUSTED],
             status_hits[STS_STACK_FULL]);
    if (errors == 0 && awaited_replies.size() == 0)
      $display("thread_id_allocator_map_unit verification clean");
    else
      $display("thread_id_allocator_map_unit verification failed");
    $finish;
  end

endmodule
